// ----- hw/rtl/rgbyp_pkg.sv -----
// Shared types, widths and BT.601 matrix constants for the RGB to YPbPr converter.
package rgbyp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = 35;
  localparam int NUM_W     = 33;
  localparam int LIM_W     = 34;
  localparam int DIV_W     = 17;
  localparam int QUO_W     = 16;
  localparam int OUT_W     = 16;
  localparam int NCH       = 3;
  localparam int DIV_STEPS = 16;
  localparam int PRE_STG   = 6;
  localparam int NSTG      = PRE_STG + DIV_STEPS + 1;

  localparam int LUMA_SH   = 15;
  localparam int CHROMA_SH = 14;

  localparam logic [SAMPLE_W-1:0] FS_RESET   = 16'd255;
  localparam logic [OUT_W-1:0]    LUMA_MAX   = OUT_W'(1 << LUMA_SH);
  localparam logic [OUT_W-1:0]    CHROMA_MAX = OUT_W'(1 << CHROMA_SH);

  // channel order
  localparam int CH_Y  = 0;
  localparam int CH_PB = 1;
  localparam int CH_PR = 2;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
  } pix_in_t;

  typedef struct packed {
    logic        [OUT_W-1:0] luma;
    logic signed [OUT_W-1:0] blue_difference;
    logic signed [OUT_W-1:0] red_difference;
  } pix_out_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [NUM_W-1:0] num;
  } div_in_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [QUO_W-1:0] quo;
  } div_out_t;

  // Matrix with 1.0 = 65536, row = output channel, column = R, G, B
  function automatic coef_t coef_of(input logic [3:0] idx);
    coef_t c;
    unique case (idx)
      4'd0:    c = 18'sd19595;
      4'd1:    c = 18'sd38470;
      4'd2:    c = 18'sd7471;
      4'd3:    c = -18'sd11058;
      4'd4:    c = -18'sd21710;
      4'd5:    c = 18'sd32768;
      4'd6:    c = 18'sd32768;
      4'd7:    c = -18'sd27439;
      4'd8:    c = -18'sd5329;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/rgbyp_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, sign and clip flags carried along.
module rgbyp_div_pipe
  import rgbyp_pkg::*;
(
  input  logic                 clk,
  input  logic [DIV_STEPS-1:0] ld,
  input  div_in_t              din,
  input  logic [DIV_W-1:0]     divisor,
  output div_out_t             dout
);

  logic [NUM_W-1:0] rem_r [DIV_STEPS];
  logic [QUO_W-1:0] quo_r [DIV_STEPS];
  logic             neg_r [DIV_STEPS];
  logic             sat_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int B = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0] rem_in, dsh, rem_nxt;
    logic [QUO_W-1:0] quo_in, quo_nxt;
    logic             neg_in, sat_in;

    if (j == 0) begin : g_first
      assign rem_in = din.num;
      assign quo_in = '0;
      assign neg_in = din.neg;
      assign sat_in = din.sat;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign quo_in = quo_r[j-1];
      assign neg_in = neg_r[j-1];
      assign sat_in = sat_r[j-1];
    end

    assign dsh = NUM_W'(divisor) << B;

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= dsh) begin
        rem_nxt    = rem_in - dsh;
        quo_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        rem_r[j] <= rem_nxt;
        quo_r[j] <= quo_nxt;
        neg_r[j] <= neg_in;
        sat_r[j] <= sat_in;
      end
    end
  end

  assign dout.neg = neg_r[DIV_STEPS-1];
  assign dout.sat = sat_r[DIV_STEPS-1];
  assign dout.quo = quo_r[DIV_STEPS-1];

endmodule

// ----- hw/rtl/rgb_to_ypbpr_converter_core.sv -----
// Pipeline: a request passes through 23 register stages on its way to out_valid.
// Throughput: one pixel per cycle unless out_ready stalls; the 16 restoring divider stages set the depth.
// Every stage holds its own valid bit, so bubbles fill while a result waits at the output.
// Reset (synchronous, rst_n low): all valid bits clear, full-scale level returns to 255.
// Top level of the BT.601 RGB to YPbPr converter.
module rgb_to_ypbpr_converter_core
  import rgbyp_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pix_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pix_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  localparam logic [SAMPLE_W-1:0] SMASK =
    SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  logic [NSTG-1:0]     v_r;
  logic [NSTG-1:0]     rdy;
  logic [SAMPLE_W-1:0] fs_r;
  logic [SAMPLE_W-1:0] fs_eff;
  logic [DIV_W-1:0]    divisor;
  logic [LIM_W-1:0]    lim [NCH];

  logic [SAMPLE_W-1:0]      smp_r  [NCH];
  logic signed [PROD_W-1:0] prod_r [NCH*NCH];
  logic signed [PROD_W-1:0] acc_r  [NCH];
  logic                     neg3_r [NCH];
  logic [NUM_W-1:0]         mag_r  [NCH];
  logic                     neg4_r [NCH];
  logic [NUM_W-1:0]         num_r  [NCH];
  div_in_t                  din_r  [NCH];
  div_out_t                 dout   [NCH];
  pix_out_t                 out_r;

  // full-scale register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fs_r <= cfg_data;
    end
  end

  assign fs_eff  = (fs_r == '0) ? SAMPLE_W'(1) : fs_r;
  assign divisor = {fs_eff, 1'b0};

  assign lim[CH_Y]  = (LIM_W'(divisor) << LUMA_SH) + LIM_W'(divisor);
  assign lim[CH_PB] = (LIM_W'(divisor) << CHROMA_SH) + LIM_W'(divisor);
  assign lim[CH_PR] = lim[CH_PB];

  // stage flow control
  assign rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // s0: masked samples
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      smp_r[0] <= in_data.red_sample & SMASK;
      smp_r[1] <= in_data.green_sample & SMASK;
      smp_r[2] <= in_data.blue_sample & SMASK;
    end
  end

  // s1: products
  for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
    for (genvar c = 0; c < NCH; c++) begin : g_mul
      logic signed [SAMPLE_W:0] sx;
      assign sx = $signed({1'b0, smp_r[c]});
      always_ff @(posedge clk) begin
        if (rdy[1]) begin
          prod_r[ch*NCH+c] <= sx * coef_of(4'(ch*NCH + c));
        end
      end
    end

    // s2..s5: sum, magnitude, rounding offset, clip test
    always_ff @(posedge clk) begin
      if (rdy[2]) begin
        acc_r[ch] <= prod_r[ch*NCH] + prod_r[ch*NCH+1] + prod_r[ch*NCH+2];
      end
      if (rdy[3]) begin
        neg3_r[ch] <= acc_r[ch][PROD_W-1];
        mag_r[ch]  <= acc_r[ch][PROD_W-1] ? NUM_W'(-acc_r[ch]) : NUM_W'(acc_r[ch]);
      end
      if (rdy[4]) begin
        neg4_r[ch] <= neg3_r[ch];
        num_r[ch]  <= mag_r[ch] + NUM_W'(fs_eff);
      end
      if (rdy[5]) begin
        din_r[ch].neg <= neg4_r[ch];
        din_r[ch].sat <= LIM_W'(num_r[ch]) >= lim[ch];
        din_r[ch].num <= num_r[ch];
      end
    end

    rgbyp_div_pipe u_div (
      .clk     (clk),
      .ld      (rdy[PRE_STG +: DIV_STEPS]),
      .din     (din_r[ch]),
      .divisor (divisor),
      .dout    (dout[ch])
    );
  end

  // output stage: saturate and restore sign
  logic [OUT_W-1:0] pb_mag, pr_mag;
  assign pb_mag = dout[CH_PB].sat ? CHROMA_MAX : dout[CH_PB].quo;
  assign pr_mag = dout[CH_PR].sat ? CHROMA_MAX : dout[CH_PR].quo;

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      out_r.luma <= dout[CH_Y].neg ? '0 :
                    (dout[CH_Y].sat ? LUMA_MAX : dout[CH_Y].quo);
      out_r.blue_difference <= dout[CH_PB].neg ? $signed(-pb_mag) : $signed(pb_mag);
      out_r.red_difference  <= dout[CH_PR].neg ? $signed(-pr_mag) : $signed(pr_mag);
    end
  end

endmodule

// ----- hw/rtl/rgbyp_checker.sv -----
// Port-level checks for the converter core, bound to the top level.
module rgbyp_checker
  import rgbyp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data
);

  localparam logic signed [OUT_W-1:0] CMAX = $signed(CHROMA_MAX);

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.luma <= LUMA_MAX)
    else $error("luma outside 0..1");

  a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.blue_difference <= CMAX) && (out_data.blue_difference >= -CMAX)
                  && (out_data.red_difference <= CMAX) && (out_data.red_difference >= -CMAX))
    else $error("chroma outside -0.5..0.5");

  a_stall_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !out_ready && out_valid |=> out_valid)
    else $error("result lost while stalled");

endmodule

bind rgb_to_ypbpr_converter_core rgbyp_checker u_rgbyp_checker (.*);
